// ----- rtl/prgn_pkg.sv -----
// ----------------------------------------------------------------------------
// prgn_pkg
// Shared constants, codes and memory request types for the partition-grouped
// renumbering core.
// ----------------------------------------------------------------------------
`default_nettype none

package prgn_pkg;

  localparam int MAX_NODES      = 1024;
  localparam int MAX_PARTITIONS = 256;

  localparam int NODE_AW = $clog2(MAX_NODES);       // node / table index
  localparam int PART_AW = $clog2(MAX_PARTITIONS);  // partition index
  localparam int CNT_W   = NODE_AW + 1;             // counts up to MAX_NODES
  localparam int NP_W    = 9;                       // num_partitions register
  localparam int CMD_W   = 2;
  localparam int ST_W    = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINAL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_O2N   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_N2O   = 2'd3;

  // result status
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd1;
  localparam logic [ST_W-1:0] ST_PART_RANGE = 3'd2;
  localparam logic [ST_W-1:0] ST_PHASE      = 3'd3;
  localparam logic [ST_W-1:0] ST_INDEX      = 3'd4;
  localparam logic [ST_W-1:0] ST_UNMAPPED   = 3'd5;

  // register map
  localparam logic REG_NUM_PARTITIONS = 1'b0;

  typedef struct packed {
    logic [PART_AW-1:0] part;
    logic               unmapped;
    logic [NODE_AW-1:0] rank;
  } node_rec_t;

  typedef struct packed {
    logic               unmapped;
    logic [NODE_AW-1:0] idx;
  } map_ent_t;

  typedef struct packed {
    logic               re;
    logic [PART_AW-1:0] raddr;
    logic               we;
    logic [PART_AW-1:0] waddr;
    logic [CNT_W-1:0]   wdata;
  } cnt_req_t;

  typedef struct packed {
    logic               re;
    logic [NODE_AW-1:0] raddr;
    logic               we;
    logic [NODE_AW-1:0] waddr;
    node_rec_t          wdata;
  } node_req_t;

  typedef struct packed {
    logic               re;
    logic [NODE_AW-1:0] raddr;
    logic               o2n_we;
    logic [NODE_AW-1:0] o2n_addr;
    map_ent_t           o2n_data;
    logic               n2o_we;
    logic [NODE_AW-1:0] n2o_addr;
    logic [NODE_AW-1:0] n2o_data;
  } map_req_t;

endpackage

`default_nettype wire

// ----- rtl/partition_grouped_renumbering_core.sv -----
// ----------------------------------------------------------------------------
// partition_grouped_renumbering_core
// Stable counting-sort renumbering: nodes are grouped by ascending partition,
// keeping load order within a partition, with old-to-new and new-to-old
// lookups after a finalize command.
// ----------------------------------------------------------------------------
// Latency: load and lookup hold busy for 1 cycle after the accepting edge; the
//   result strobe (done) is high in the cycle after that, for exactly one cycle.
//   A new transaction is taken only while idle, which is again so while done is high;
//   a load reads its count from memory, registered, and writes it back in S_EXEC.
// Finalize: the prefix pass reads (S_PF_RD) and rewrites (S_PF_WR) each count of the
//   partitions in use; the node pass reads a node record (S_ND_RD), then, unless the node
//   is unmapped, its partition offset (S_ND_CK), and writes both tables (S_ND_WR).
// Reset: synchronous, active high; counts read as zero, num_partitions is 1.
// The receiver cannot stall: results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_grouped_renumbering_core (
  input  wire                                clk,
  input  wire                                rst,
  // command channel
  input  wire                                start,
  output logic                               busy,
  input  wire  [prgn_pkg::CMD_W-1:0]         cmd,
  input  wire  [prgn_pkg::PART_AW-1:0]       partition_id,
  input  wire  [prgn_pkg::NODE_AW-1:0]       query_index,
  // result channel
  output logic                               done,
  output logic [prgn_pkg::ST_W-1:0]          status,
  output logic [prgn_pkg::NODE_AW-1:0]       mapped_index,
  output logic [prgn_pkg::CNT_W-1:0]         total_nodes,
  output logic [prgn_pkg::CNT_W-1:0]         total_mapped,
  // APB configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [2:0]                         paddr,
  input  wire  [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for start
  localparam logic [2:0] S_EXEC  = 3'd1;  // read data back, resolve load/lookup or start finalize
  localparam logic [2:0] S_PF_RD = 3'd2;  // prefix pass: read count
  localparam logic [2:0] S_PF_WR = 3'd3;  // prefix pass: write offset
  localparam logic [2:0] S_ND_RD = 3'd4;  // node pass: read node record
  localparam logic [2:0] S_ND_CK = 3'd5;  // node pass: check, read offset
  localparam logic [2:0] S_ND_WR = 3'd6;  // node pass: write both tables
  localparam logic [2:0] S_FIN   = 3'd7;  // finalize result

  localparam logic [prgn_pkg::CNT_W-1:0] FULL_COUNT = prgn_pkg::CNT_W'(prgn_pkg::MAX_NODES);
  localparam logic [prgn_pkg::NP_W-1:0]  NP_MAX     = prgn_pkg::NP_W'(prgn_pkg::MAX_PARTITIONS);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [2:0]                    state, state_next;
  logic [prgn_pkg::CNT_W-1:0]    loaded_count, loaded_count_next;
  logic [prgn_pkg::CNT_W-1:0]    mapped_count, mapped_count_next;
  logic                          finalized, finalized_next;
  logic [prgn_pkg::NP_W-1:0]     num_partitions;
  logic [prgn_pkg::NP_W-1:0]     part_ptr, part_ptr_next;   // prefix pass partition
  logic [prgn_pkg::CNT_W-1:0]    node_ptr, node_ptr_next;   // node pass index
  logic [prgn_pkg::CNT_W-1:0]    sum, sum_next;             // running offset

  // command held for the duration of the transaction
  logic [prgn_pkg::CMD_W-1:0]    cmd_q;
  logic [prgn_pkg::PART_AW-1:0]  part_q;
  logic [prgn_pkg::NODE_AW-1:0]  query_q;

  // result to be registered onto the output ports
  logic                          res_fire;
  logic [prgn_pkg::ST_W-1:0]     res_status;
  logic [prgn_pkg::NODE_AW-1:0]  res_mapped;

  // memory interfaces
  prgn_pkg::cnt_req_t            cnt_req;
  prgn_pkg::node_req_t           node_req;
  prgn_pkg::map_req_t            map_req;
  logic [prgn_pkg::CNT_W-1:0]    cnt_rdata;
  prgn_pkg::node_rec_t           node_rdata;
  prgn_pkg::map_ent_t            o2n_rdata;
  logic [prgn_pkg::NODE_AW-1:0]  n2o_rdata;

  logic                          accept;
  logic [prgn_pkg::NP_W-1:0]     parts_used;
  logic [prgn_pkg::NP_W-1:0]     part_ptr_inc;
  logic [prgn_pkg::CNT_W-1:0]    node_ptr_inc;
  logic [prgn_pkg::CNT_W-1:0]    dst;
  logic                          cfg_write;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // effective partition count; a partition id is out of range when
  // {0,id} >= num_partitions, which also covers counts above MAX_PARTITIONS
  assign parts_used   = (num_partitions > NP_MAX) ? NP_MAX : num_partitions;
  assign part_ptr_inc = part_ptr + 1'b1;
  assign node_ptr_inc = node_ptr + 1'b1;

  // new index = partition offset + rank (offset sits in the count store now)
  assign dst = cnt_rdata + {1'b0, node_rdata.rank};

  // ---------------------------------------------------------------------------
  // Sequencer and memory requests
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next        = state;
    loaded_count_next = loaded_count;
    mapped_count_next = mapped_count;
    finalized_next    = finalized;
    part_ptr_next     = part_ptr;
    node_ptr_next     = node_ptr;
    sum_next          = sum;
    res_fire          = 1'b0;
    res_status        = prgn_pkg::ST_OK;
    res_mapped        = '0;
    cnt_req           = '0;
    node_req          = '0;
    map_req           = '0;

    unique case (state)
      S_IDLE: begin
        // speculative reads: count of the loaded partition, both map tables
        cnt_req.re    = 1'b1;
        cnt_req.raddr = partition_id;
        map_req.re    = 1'b1;
        map_req.raddr = query_index;
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_IDLE;
        res_fire   = 1'b1;
        unique case (cmd_q)
          prgn_pkg::CMD_LOAD: begin
            if (finalized) begin
              res_status = prgn_pkg::ST_PHASE;
            end else if (loaded_count == FULL_COUNT) begin
              res_status = prgn_pkg::ST_FULL;
            end else begin
              node_req.we          = 1'b1;
              node_req.waddr       = loaded_count[prgn_pkg::NODE_AW-1:0];
              node_req.wdata.part  = part_q;
              loaded_count_next    = loaded_count_next + 1'b1;
              if ({1'b0, part_q} >= num_partitions) begin
                res_status              = prgn_pkg::ST_PART_RANGE;
                node_req.wdata.unmapped = 1'b1;
                node_req.wdata.rank     = '0;
              end else begin
                node_req.wdata.unmapped = 1'b0;
                node_req.wdata.rank     = cnt_rdata[prgn_pkg::NODE_AW-1:0];
                cnt_req.we              = 1'b1;
                cnt_req.waddr           = part_q;
                cnt_req.wdata           = cnt_rdata + 1'b1;
              end
            end
          end

          prgn_pkg::CMD_FINAL: begin
            if (finalized) begin
              res_status = prgn_pkg::ST_PHASE;
            end else begin
              res_fire          = 1'b0;
              part_ptr_next     = '0;
              node_ptr_next     = '0;
              sum_next          = '0;
              mapped_count_next = '0;
              if (parts_used != '0) begin
                state_next = S_PF_RD;
              end else if (loaded_count == '0) begin
                state_next = S_FIN;
              end else begin
                state_next = S_ND_RD;
              end
            end
          end

          prgn_pkg::CMD_O2N: begin
            if (!finalized) begin
              res_status = prgn_pkg::ST_PHASE;
            end else if ({1'b0, query_q} >= loaded_count) begin
              res_status = prgn_pkg::ST_INDEX;
            end else if (o2n_rdata.unmapped) begin
              res_status = prgn_pkg::ST_UNMAPPED;
            end else begin
              res_mapped = o2n_rdata.idx;
            end
          end

          prgn_pkg::CMD_N2O: begin
            if (!finalized) begin
              res_status = prgn_pkg::ST_PHASE;
            end else if ({1'b0, query_q} >= mapped_count) begin
              res_status = prgn_pkg::ST_INDEX;
            end else begin
              res_mapped = n2o_rdata;
            end
          end

          default: begin
            res_status = prgn_pkg::ST_PHASE;
          end
        endcase
      end

      // exclusive prefix sum, rewriting counts as offsets in place
      S_PF_RD: begin
        cnt_req.re    = 1'b1;
        cnt_req.raddr = part_ptr[prgn_pkg::PART_AW-1:0];
        state_next    = S_PF_WR;
      end

      S_PF_WR: begin
        cnt_req.we    = 1'b1;
        cnt_req.waddr = part_ptr[prgn_pkg::PART_AW-1:0];
        cnt_req.wdata = sum;
        sum_next      = sum + cnt_rdata;
        part_ptr_next = part_ptr_inc;
        if (part_ptr_inc < parts_used) begin
          state_next = S_PF_RD;
        end else if (loaded_count == '0) begin
          state_next = S_FIN;
        end else begin
          state_next = S_ND_RD;
        end
      end

      S_ND_RD: begin
        node_req.re    = 1'b1;
        node_req.raddr = node_ptr[prgn_pkg::NODE_AW-1:0];
        state_next     = S_ND_CK;
      end

      S_ND_CK: begin
        if (node_rdata.unmapped || ({1'b0, node_rdata.part} >= num_partitions)) begin
          map_req.o2n_we            = 1'b1;
          map_req.o2n_addr          = node_ptr[prgn_pkg::NODE_AW-1:0];
          map_req.o2n_data.unmapped = 1'b1;
          map_req.o2n_data.idx      = '0;
          node_ptr_next             = node_ptr_inc;
          state_next = (node_ptr_inc == loaded_count) ? S_FIN : S_ND_RD;
        end else begin
          cnt_req.re    = 1'b1;
          cnt_req.raddr = node_rdata.part;
          state_next    = S_ND_WR;
        end
      end

      S_ND_WR: begin
        map_req.o2n_we   = 1'b1;
        map_req.o2n_addr = node_ptr[prgn_pkg::NODE_AW-1:0];
        if (dst >= FULL_COUNT) begin
          map_req.o2n_data.unmapped = 1'b1;
          map_req.o2n_data.idx      = '0;
        end else begin
          map_req.o2n_data.unmapped = 1'b0;
          map_req.o2n_data.idx      = dst[prgn_pkg::NODE_AW-1:0];
          map_req.n2o_we            = 1'b1;
          map_req.n2o_addr          = dst[prgn_pkg::NODE_AW-1:0];
          map_req.n2o_data          = node_ptr[prgn_pkg::NODE_AW-1:0];
          mapped_count_next         = mapped_count + 1'b1;
        end
        node_ptr_next = node_ptr_inc;
        state_next    = (node_ptr_inc == loaded_count) ? S_FIN : S_ND_RD;
      end

      S_FIN: begin
        finalized_next = 1'b1;
        res_fire       = 1'b1;
        state_next     = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      mapped_count <= '0;
      finalized    <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      loaded_count <= loaded_count_next;
      mapped_count <= mapped_count_next;
      finalized    <= finalized_next;
      done         <= res_fire;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    part_ptr <= part_ptr_next;
    node_ptr <= node_ptr_next;
    sum      <= sum_next;
    if (accept) begin
      cmd_q   <= cmd;
      part_q  <= partition_id;
      query_q <= query_index;
    end
    if (res_fire) begin
      status       <= res_status;
      mapped_index <= res_mapped;
      total_nodes  <= loaded_count_next;
      total_mapped <= mapped_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // APB configuration: one register, num_partitions at byte address 0
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_partitions <= prgn_pkg::NP_W'(1);
    end else if (cfg_write && (paddr[2] == prgn_pkg::REG_NUM_PARTITIONS)) begin
      num_partitions <= pwdata[prgn_pkg::NP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == prgn_pkg::REG_NUM_PARTITIONS) begin
      prdata[prgn_pkg::NP_W-1:0] = num_partitions;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  prgn_count_store u_count (
    .clk   (clk),
    .rst   (rst),
    .req   (cnt_req),
    .rdata (cnt_rdata)
  );

  prgn_node_store u_node (
    .clk   (clk),
    .req   (node_req),
    .rdata (node_rdata)
  );

  prgn_map_store u_map (
    .clk       (clk),
    .req       (map_req),
    .o2n_rdata (o2n_rdata),
    .n2o_rdata (n2o_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // an accepted transaction always occupies the block for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not start");

  // never more nodes than the store holds, never more mapped than loaded
  a_counts: assert property (@(posedge clk) disable iff (rst)
    (loaded_count <= FULL_COUNT) && (mapped_count <= loaded_count))
    else $error("node counters out of range");

  // the finalized flag only rises at the end of the finalize sequence (S_FIN)
  a_final_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(finalized) |-> $past(state == S_FIN))
    else $error("finalized set outside the finalize sequence");

endmodule

`default_nettype wire

// ----- rtl/prgn_count_store.sv -----
// ----------------------------------------------------------------------------
// prgn_count_store
// Per-partition counter memory; holds counts while loading and start offsets
// after the prefix pass. Valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module prgn_count_store (
  input  wire                          clk,
  input  wire                          rst,
  input  prgn_pkg::cnt_req_t           req,
  output logic [prgn_pkg::CNT_W-1:0]   rdata
);

  logic [prgn_pkg::CNT_W-1:0]          mem [prgn_pkg::MAX_PARTITIONS];
  logic [prgn_pkg::MAX_PARTITIONS-1:0] valid;
  logic [prgn_pkg::CNT_W-1:0]          rd_q;
  logic                                rd_vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_vld <= valid[req.raddr];
      end
    end
  end

  // never-written entry reads as zero
  assign rdata = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// ----- rtl/prgn_node_store.sv -----
// ----------------------------------------------------------------------------
// prgn_node_store
// Per-node record memory: partition, unmapped flag and rank within partition.
// Read data holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module prgn_node_store (
  input  wire                    clk,
  input  prgn_pkg::node_req_t    req,
  output prgn_pkg::node_rec_t    rdata
);

  prgn_pkg::node_rec_t mem [prgn_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/prgn_map_store.sv -----
// ----------------------------------------------------------------------------
// prgn_map_store
// Old-to-new and new-to-old tables. Both are read at one query address;
// the old-to-new entry carries the unmapped flag.
// ----------------------------------------------------------------------------
`default_nettype none

module prgn_map_store (
  input  wire                          clk,
  input  prgn_pkg::map_req_t           req,
  output prgn_pkg::map_ent_t           o2n_rdata,
  output logic [prgn_pkg::NODE_AW-1:0] n2o_rdata
);

  prgn_pkg::map_ent_t          o2n_mem [prgn_pkg::MAX_NODES];
  logic [prgn_pkg::NODE_AW-1:0] n2o_mem [prgn_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (req.o2n_we) begin
      o2n_mem[req.o2n_addr] <= req.o2n_data;
    end
    if (req.re) begin
      o2n_rdata <= o2n_mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.n2o_we) begin
      n2o_mem[req.n2o_addr] <= req.n2o_data;
    end
    if (req.re) begin
      n2o_rdata <= n2o_mem[req.raddr];
    end
  end

endmodule

`default_nettype wire
